### rtl/core/lscc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line sensor calibrate/classify - shared package
// Field widths, command and decision codes, and request/response types.
// ----------------------------------------------------------------------------
package lscc_pkg;

   localparam int SAMPLE_BITS       = 10;
   localparam int LEVEL_SCALE_DEF   = 100;
   localparam int LEVEL_W           = 7;
   localparam int NUM_PAIRS         = 3;

   localparam logic [LEVEL_W-1:0] THRESH_RESET = 7'd50;

   localparam logic [1:0] CMD_CAL      = 2'd0;
   localparam logic [1:0] CMD_CLASSIFY = 2'd1;
   localparam logic [1:0] CMD_CLEAR    = 2'd2;

   localparam logic [1:0] DEC_NONE  = 2'd0;
   localparam logic [1:0] DEC_LEFT  = 2'd1;
   localparam logic [1:0] DEC_RIGHT = 2'd2;
   localparam logic [1:0] DEC_BOTH  = 2'd3;

   typedef struct packed {
      logic [1:0]             cmd;
      logic [1:0]             sensor_pair;
      logic [SAMPLE_BITS-1:0] left_sample;
      logic [SAMPLE_BITS-1:0] right_sample;
   } req_type;

   typedef struct packed {
      logic [1:0]         decision;
      logic [LEVEL_W-1:0] left_level;
      logic [LEVEL_W-1:0] right_level;
      logic               span_zero;
   } rsp_type;

endpackage

### rtl/core/line_sensor_calibrate_classify_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line sensor calibrate/classify unit
// Keeps running min/max per sensor channel and maps readings to a percent
// level through one shared multiply and restoring divide sequencer.
// ----------------------------------------------------------------------------
// Requests other than a classify of a valid pair go from idle through the
// response state and back to idle. For a classify request, each of the two
// channels in turn goes through load, multiply, range check, 7 restoring
// divide steps and a store on the same shared datapath; then the response
// is formed and the unit returns to idle. A channel with a zero span, or
// whose level is 128 or more, skips the 7 divide steps. req_stall is high
// while a request is in work. A finished response sits in an output register,
// so the next request is taken while it waits; a request that finishes while
// the previous response is still stalled holds in the response state until
// that response is taken.
module line_sensor_calibrate_classify_unit #(
   parameter int LEVEL_SCALE = lscc_pkg::LEVEL_SCALE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  lscc_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output lscc_pkg::rsp_type                 rsp_data,
   input  logic                              csr_wr_en,
   input  logic [lscc_pkg::LEVEL_W-1:0]      csr_wr_data
);
   import lscc_pkg::*;

   localparam int SB       = SAMPLE_BITS;
   localparam int SCALE_W  = $clog2(LEVEL_SCALE + 1);
   localparam int NUM_W    = SB + SCALE_W;
   localparam int DEN_W    = SB + LEVEL_W;
   localparam int CMP_W    = (NUM_W > DEN_W) ? NUM_W : DEN_W;
   localparam int STEP_W   = $clog2(LEVEL_W);
   localparam int Q_W      = LEVEL_W + 1;
   localparam logic [LEVEL_W-1:0] LEVEL_SAT =
      LEVEL_W'((LEVEL_SCALE > 127) ? 127 : LEVEL_SCALE);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(LEVEL_W - 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOAD = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_CHK  = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_SIDE = 3'd5;
   localparam logic [2:0] ST_FIN  = 3'd6;

   logic [2:0]         state_ff, state_in;
   req_type            req_ff, req_in;
   logic               cls_ff, cls_in;
   logic               side_ff, side_in;
   logic [LEVEL_W-1:0] thresh_ff, thresh_in;

   logic [SB-1:0] max_l_ff [NUM_PAIRS], max_l_in [NUM_PAIRS];
   logic [SB-1:0] max_r_ff [NUM_PAIRS], max_r_in [NUM_PAIRS];
   logic [SB-1:0] min_l_ff [NUM_PAIRS], min_l_in [NUM_PAIRS];
   logic [SB-1:0] min_r_ff [NUM_PAIRS], min_r_in [NUM_PAIRS];

   logic [SB-1:0]     diff_mag_ff, diff_mag_in;
   logic [SB-1:0]     span_mag_ff, span_mag_in;
   logic              sign_ff, sign_in;
   logic              zero_ff, zero_in;
   logic [CMP_W-1:0]  rem_ff, rem_in;
   logic [CMP_W-1:0]  div_ff, div_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [Q_W-1:0]    q_ff, q_in;

   logic [Q_W-1:0] lvl_l_ff, lvl_l_in;
   logic           neg_l_ff, neg_l_in;
   logic [Q_W-1:0] lvl_r_ff, lvl_r_in;
   logic           neg_r_ff, neg_r_in;
   logic           span_any_ff, span_any_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic             accept;
   logic [1:0]       pidx;
   logic [SB-1:0]    x_sel, lo_sel, hi_sel;
   logic [SB:0]      diff, span;
   logic [NUM_W-1:0] prod;
   logic [CMP_W-1:0] den_top;
   logic             q_bit;
   logic             neg_now;
   logic [Q_W-1:0]   thr_ext;
   logic             lgt, llt, rgt, rlt;
   logic [1:0]       dec;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign pidx      = req_ff.sensor_pair;

   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      cls_in      = cls_ff;
      side_in     = side_ff;
      thresh_in   = thresh_ff;
      max_l_in    = max_l_ff;
      max_r_in    = max_r_ff;
      min_l_in    = min_l_ff;
      min_r_in    = min_r_ff;
      diff_mag_in = diff_mag_ff;
      span_mag_in = span_mag_ff;
      sign_in     = sign_ff;
      zero_in     = zero_ff;
      rem_in      = rem_ff;
      div_in      = div_ff;
      step_in     = step_ff;
      q_in        = q_ff;
      lvl_l_in    = lvl_l_ff;
      neg_l_in    = neg_l_ff;
      lvl_r_in    = lvl_r_ff;
      neg_r_in    = neg_r_ff;
      span_any_in = span_any_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in      = rsp_ff;

      x_sel   = side_ff ? req_ff.right_sample : req_ff.left_sample;
      lo_sel  = side_ff ? min_r_ff[pidx] : min_l_ff[pidx];
      hi_sel  = side_ff ? max_r_ff[pidx] : max_l_ff[pidx];
      diff    = {1'b0, x_sel} - {1'b0, lo_sel};
      span    = {1'b0, hi_sel} - {1'b0, lo_sel};
      prod    = NUM_W'(diff_mag_ff) * NUM_W'(LEVEL_SCALE);
      den_top = CMP_W'(span_mag_ff) << LEVEL_W;
      q_bit   = (rem_ff >= div_ff);
      neg_now = sign_ff && (q_ff != '0);

      thr_ext = {1'b0, thresh_ff};
      lgt = !neg_l_ff && (lvl_l_ff > thr_ext);
      llt = neg_l_ff || (lvl_l_ff < thr_ext);
      rgt = !neg_r_ff && (lvl_r_ff > thr_ext);
      rlt = neg_r_ff || (lvl_r_ff < thr_ext);
      if (lgt && rlt) begin
         dec = DEC_LEFT;
      end else if (rgt && llt) begin
         dec = DEC_RIGHT;
      end else if (lgt && rgt) begin
         dec = DEC_BOTH;
      end else begin
         dec = DEC_NONE;
      end

      if (csr_wr_en) begin
         thresh_in = csr_wr_data;
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in      = req_data;
               side_in     = 1'b0;
               span_any_in = 1'b0;
               cls_in      = (req_data.cmd == CMD_CLASSIFY) &&
                             (req_data.sensor_pair < 2'(NUM_PAIRS));
               if ((req_data.cmd == CMD_CAL) &&
                   (req_data.sensor_pair < 2'(NUM_PAIRS))) begin
                  if (max_l_ff[req_data.sensor_pair] < req_data.left_sample)
                     max_l_in[req_data.sensor_pair] = req_data.left_sample;
                  if (min_l_ff[req_data.sensor_pair] > req_data.left_sample)
                     min_l_in[req_data.sensor_pair] = req_data.left_sample;
                  if (max_r_ff[req_data.sensor_pair] < req_data.right_sample)
                     max_r_in[req_data.sensor_pair] = req_data.right_sample;
                  if (min_r_ff[req_data.sensor_pair] > req_data.right_sample)
                     min_r_in[req_data.sensor_pair] = req_data.right_sample;
               end
               if (req_data.cmd == CMD_CLEAR) begin
                  for (int i = 0; i < NUM_PAIRS; i++) begin
                     max_l_in[i] = '0;
                     max_r_in[i] = '0;
                     min_l_in[i] = '1;
                     min_r_in[i] = '1;
                  end
               end
               if ((req_data.cmd == CMD_CLASSIFY) &&
                   (req_data.sensor_pair < 2'(NUM_PAIRS))) begin
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_LOAD: begin
            diff_mag_in = diff[SB] ? SB'(~diff + 1'b1) : diff[SB-1:0];
            span_mag_in = span[SB] ? SB'(~span + 1'b1) : span[SB-1:0];
            sign_in     = diff[SB] ^ span[SB];
            zero_in     = (span == '0);
            state_in    = ST_MUL;
         end
         ST_MUL: begin
            rem_in   = CMP_W'(prod);
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (zero_ff) begin
               q_in     = '0;
               state_in = ST_SIDE;
            end else if (rem_ff >= den_top) begin
               // quotient beyond any level or threshold
               q_in     = Q_W'(1) << LEVEL_W;
               state_in = ST_SIDE;
            end else begin
               q_in     = '0;
               div_in   = CMP_W'(span_mag_ff) << (LEVEL_W - 1);
               step_in  = STEP_LAST;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (q_bit) begin
               rem_in = rem_ff - div_ff;
            end
            q_in   = {q_ff[Q_W-2:0], q_bit};
            div_in = div_ff >> 1;
            if (step_ff == '0) begin
               state_in = ST_SIDE;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_SIDE: begin
            span_any_in = span_any_ff | zero_ff;
            if (!side_ff) begin
               lvl_l_in = q_ff;
               neg_l_in = neg_now;
               side_in  = 1'b1;
               state_in = ST_LOAD;
            end else begin
               lvl_r_in = q_ff;
               neg_r_in = neg_now;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               if (cls_ff) begin
                  rsp_in.decision    = dec;
                  rsp_in.left_level  = neg_l_ff ? '0 :
                     ((lvl_l_ff > Q_W'(LEVEL_SAT)) ? LEVEL_SAT : lvl_l_ff[LEVEL_W-1:0]);
                  rsp_in.right_level = neg_r_ff ? '0 :
                     ((lvl_r_ff > Q_W'(LEVEL_SAT)) ? LEVEL_SAT : lvl_r_ff[LEVEL_W-1:0]);
                  rsp_in.span_zero   = span_any_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         thresh_ff    <= THRESH_RESET;
         for (int i = 0; i < NUM_PAIRS; i++) begin
            max_l_ff[i] <= '0;
            max_r_ff[i] <= '0;
            min_l_ff[i] <= '1;
            min_r_ff[i] <= '1;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         thresh_ff    <= thresh_in;
         max_l_ff     <= max_l_in;
         max_r_ff     <= max_r_in;
         min_l_ff     <= min_l_in;
         min_r_ff     <= min_r_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      cls_ff      <= cls_in;
      side_ff     <= side_in;
      diff_mag_ff <= diff_mag_in;
      span_mag_ff <= span_mag_in;
      sign_ff     <= sign_in;
      zero_ff     <= zero_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      step_ff     <= step_in;
      q_ff        <= q_in;
      lvl_l_ff    <= lvl_l_in;
      neg_l_ff    <= neg_l_in;
      lvl_r_ff    <= lvl_r_in;
      neg_r_ff    <= neg_r_in;
      span_any_ff <= span_any_in;
      rsp_ff      <= rsp_in;
   end

endmodule

### dv/tb_line_sensor_calibrate_classify_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line sensor calibrate/classify unit - testbench
// Drives calibrate, classify, clear and unused requests through the unit
// under random idling on both channels, predicts every response from a
// per-channel min/max model, and checks the responses field by field.
// Threshold settings change between phases while the unit is idle.
// ----------------------------------------------------------------------------
module tb_line_sensor_calibrate_classify_unit;
   import lscc_pkg::*;

   localparam logic [1:0] CMD_UNUSED   = 2'd3;
   localparam logic [1:0] PAIR_PHOTO   = 2'd0;
   localparam logic [1:0] PAIR_IR      = 2'd1;
   localparam logic [1:0] PAIR_TURN    = 2'd2;
   localparam logic [1:0] PAIR_UNUSED  = 2'd3;
   localparam int         NUM_CHAN     = 2 * NUM_PAIRS;
   localparam int         SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;
   localparam int         DRAIN_CYCLES = 30;
   localparam int         HOLD_CYCLES  = 400;
   localparam int         IDLE_LIMIT   = 3000;
   localparam int         PHASE_ITEMS  = 229;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_wr_en = 1'b0;
   logic [LEVEL_W-1:0] csr_wr_data = '0;

   line_sensor_calibrate_classify_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // sensor model state
   logic [SAMPLE_BITS-1:0] chan_max [NUM_CHAN];
   logic [SAMPLE_BITS-1:0] chan_min [NUM_CHAN];
   logic [LEVEL_W-1:0]     thresh_model;

   req_type pending_req_q[$];
   rsp_type expected_rsp_q[$];

   int  error_count = 0;
   int  n_issued    = 0;
   int  n_checked   = 0;
   int  req_gap_max = 19;
   int  rsp_gap_max = 19;
   bit  hold_request = 1'b0;
   bit  req_taken   = 1'b0;
   bit  req_busy    = 1'b0;
   int  req_wait    = 0;
   bit  rsp_taken   = 1'b0;
   int  rsp_wait    = 0;
   int  hold_left   = 0;
   int  idle_cycles = 0;

   function automatic int draw_gap(int max_gap);
      if ($urandom_range(0, 1) == 0)
         return 0;
      return $urandom_range(0, max_gap);
   endfunction

   function automatic logic [LEVEL_W-1:0] clamp_level(int v);
      if (v < 0)
         return '0;
      if (v > LEVEL_SCALE_DEF)
         return LEVEL_W'(LEVEL_SCALE_DEF);
      return LEVEL_W'(v);
   endfunction

   function automatic int map_level(int ch, int x, inout bit zero_span);
      int lo;
      int hi;
      lo = int'(chan_min[ch]);
      hi = int'(chan_max[ch]);
      if (hi == lo) begin
         zero_span = 1'b1;
         return 0;
      end
      return ((x - lo) * LEVEL_SCALE_DEF) / (hi - lo);
   endfunction

   task automatic clear_extremes();
      for (int i = 0; i < NUM_CHAN; i++) begin
         chan_max[i] = '0;
         chan_min[i] = SAMPLE_BITS'(SAMPLE_MAX);
      end
   endtask

   task automatic widen_extremes(int ch, logic [SAMPLE_BITS-1:0] x);
      if (chan_max[ch] < x)
         chan_max[ch] = x;
      if (chan_min[ch] > x)
         chan_min[ch] = x;
   endtask

   task automatic predict_sensor_response(input req_type r);
      rsp_type e;
      int      ch;
      int      lv;
      int      rv;
      int      t;
      bit      zs;
      e  = '0;
      ch = 2 * int'(r.sensor_pair);
      case (r.cmd)
         CMD_CAL: begin
            if (r.sensor_pair != PAIR_UNUSED) begin
               widen_extremes(ch, r.left_sample);
               widen_extremes(ch + 1, r.right_sample);
            end
         end
         CMD_CLASSIFY: begin
            if (r.sensor_pair != PAIR_UNUSED) begin
               zs = 1'b0;
               t  = int'(thresh_model);
               lv = map_level(ch, int'(r.left_sample), zs);
               rv = map_level(ch + 1, int'(r.right_sample), zs);
               // decision is taken on the unsaturated levels
               if (lv > t && rv < t)
                  e.decision = DEC_LEFT;
               else if (rv > t && lv < t)
                  e.decision = DEC_RIGHT;
               else if (lv > t && rv > t)
                  e.decision = DEC_BOTH;
               else
                  e.decision = DEC_NONE;
               e.left_level  = clamp_level(lv);
               e.right_level = clamp_level(rv);
               e.span_zero   = zs;
            end
         end
         CMD_CLEAR: clear_extremes();
         default: ;
      endcase
      expected_rsp_q.push_back(e);
   endtask

   // request acceptance, prediction and response checking
   always @(posedge clock) begin
      if (reset) begin
         clear_extremes();
         thresh_model = THRESH_RESET;
      end else begin
         if (csr_wr_en)
            thresh_model = csr_wr_data;
         if (rsp_valid && !rsp_stall) begin
            rsp_taken = 1'b1;
            n_checked++;
            if (expected_rsp_q.size() == 0) begin
               $error("response with no request outstanding");
               error_count++;
            end else begin
               rsp_type e;
               e = expected_rsp_q.pop_front();
               if (rsp_data.decision !== e.decision) begin
                  $error("decision expected %0d got %0d", e.decision, rsp_data.decision);
                  error_count++;
               end
               if (rsp_data.left_level !== e.left_level) begin
                  $error("left_level expected %0d got %0d",
                         e.left_level, rsp_data.left_level);
                  error_count++;
               end
               if (rsp_data.right_level !== e.right_level) begin
                  $error("right_level expected %0d got %0d",
                         e.right_level, rsp_data.right_level);
                  error_count++;
               end
               if (rsp_data.span_zero !== e.span_zero) begin
                  $error("span_zero expected %0d got %0d",
                         e.span_zero, rsp_data.span_zero);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            predict_sensor_response(req_data);
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_taken) begin
            req_taken = 1'b0;
            req_busy  = 1'b0;
         end
         if (!req_busy) begin
            if (req_wait > 0) begin
               req_wait--;
            end else if (pending_req_q.size() > 0) begin
               req_data <= pending_req_q.pop_front();
               req_busy = 1'b1;
               req_wait = draw_gap(req_gap_max);
            end
         end
         req_valid <= req_busy;
      end
   end

   // response stall
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            rsp_wait  = draw_gap(rsp_gap_max);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles == IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic add_request(logic [1:0] cmd, logic [1:0] pair, int ls, int rs);
      req_type r;
      r.cmd          = cmd;
      r.sensor_pair  = pair;
      r.left_sample  = SAMPLE_BITS'(ls);
      r.right_sample = SAMPLE_BITS'(rs);
      pending_req_q.push_back(r);
      n_issued++;
   endtask

   function automatic int sample_near(int lo, int hi, int margin);
      int a;
      int b;
      a = (lo - margin < 0) ? 0 : lo - margin;
      b = (hi + margin > SAMPLE_MAX) ? SAMPLE_MAX : hi + margin;
      return $urandom_range(a, b);
   endfunction

   task automatic add_random_request(int win_lo, int win_hi);
      int pick;
      int margin;
      logic [1:0] pair;
      pick   = $urandom_range(0, 99);
      pair   = 2'($urandom_range(0, 2));
      margin = (win_hi - win_lo) / 8 + 4;
      if (pick < 4)
         add_request(CMD_CLEAR, 2'($urandom_range(0, 3)),
                     $urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX));
      else if (pick < 36)
         add_request(CMD_CAL, pair, $urandom_range(win_lo, win_hi),
                     $urandom_range(win_lo, win_hi));
      else if (pick < 86)
         add_request(CMD_CLASSIFY, pair, sample_near(win_lo, win_hi, margin),
                     sample_near(win_lo, win_hi, margin));
      else if (pick < 92)
         add_request(CMD_CLASSIFY, pair, $urandom_range(0, SAMPLE_MAX),
                     $urandom_range(0, SAMPLE_MAX));
      else if (pick < 96)
         add_request(2'($urandom_range(0, 1)), PAIR_UNUSED,
                     $urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX));
      else
         add_request(CMD_UNUSED, 2'($urandom_range(0, 3)),
                     $urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX));
   endtask

   task automatic wait_drained();
      wait (n_checked >= n_issued);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(logic [LEVEL_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [LEVEL_W-1:0] thresh_plan [8];
      int win_lo;
      int win_hi;
      thresh_plan = '{7'd0, 7'd100, 7'd75, 7'd27, 7'd50, 7'd0, 7'd0, 7'd100};
      thresh_plan[5] = LEVEL_W'($urandom_range(0, LEVEL_SCALE_DEF));
      thresh_plan[6] = LEVEL_W'($urandom_range(0, LEVEL_SCALE_DEF));

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reversed span after reset, unused codes, zero span,
      // saturation, threshold ties and a clear
      add_request(CMD_CLASSIFY, PAIR_PHOTO, 0, SAMPLE_MAX);
      add_request(CMD_CLASSIFY, PAIR_UNUSED, SAMPLE_MAX, SAMPLE_MAX);
      add_request(CMD_UNUSED, PAIR_UNUSED, SAMPLE_MAX, SAMPLE_MAX);
      add_request(CMD_CAL, PAIR_PHOTO, 100, 100);
      add_request(CMD_CLASSIFY, PAIR_PHOTO, 100, 500);
      add_request(CMD_CAL, PAIR_PHOTO, 900, 1000);
      add_request(CMD_CLASSIFY, PAIR_PHOTO, SAMPLE_MAX, 0);
      add_request(CMD_CLASSIFY, PAIR_PHOTO, 500, 550);
      add_request(CMD_CAL, PAIR_UNUSED, SAMPLE_MAX, 0);
      add_request(CMD_CAL, PAIR_IR, 0, 0);
      add_request(CMD_CAL, PAIR_IR, SAMPLE_MAX, SAMPLE_MAX);
      add_request(CMD_CLASSIFY, PAIR_IR, SAMPLE_MAX, 0);
      add_request(CMD_CLASSIFY, PAIR_IR, 0, SAMPLE_MAX);
      add_request(CMD_CLASSIFY, PAIR_IR, SAMPLE_MAX, SAMPLE_MAX);
      add_request(CMD_CLASSIFY, PAIR_IR, 512, 0);
      add_request(CMD_CLASSIFY, PAIR_IR, 512, 512);
      add_request(CMD_CAL, PAIR_TURN, 10, 20);
      add_request(CMD_CAL, PAIR_TURN, 30, 20);
      add_request(CMD_CLASSIFY, PAIR_TURN, 30, 20);
      add_request(CMD_CLASSIFY, PAIR_TURN, 0, SAMPLE_MAX);
      add_request(CMD_CLEAR, PAIR_UNUSED, 0, 0);
      add_request(CMD_CLASSIFY, PAIR_IR, 0, 0);
      add_request(CMD_CLASSIFY, PAIR_TURN, SAMPLE_MAX, 341);
      wait_drained();

      for (int ph = 0; ph < 8; ph++) begin
         write_threshold(thresh_plan[ph]);
         req_gap_max = (ph == 3) ? 0 : 19;
         rsp_gap_max = (ph == 3) ? 0 : 19;
         if (ph == 0 || ph == 7) begin
            win_lo = 0;
            win_hi = SAMPLE_MAX;
         end else begin
            win_lo = $urandom_range(0, 900);
            win_hi = win_lo + $urandom_range(0, SAMPLE_MAX - win_lo);
         end
         add_request(CMD_CLEAR, PAIR_PHOTO, 0, 0);
         for (int i = 0; i < PHASE_ITEMS; i++)
            add_random_request(win_lo, win_hi);
         // hold the response side off while requests keep coming
         if (ph == 1)
            hold_request = 1'b1;
         wait_drained();
      end

      if (expected_rsp_q.size() != 0) begin
         $error("%0d responses never arrived", expected_rsp_q.size());
         error_count++;
      end
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

### files.f
rtl/core/lscc_pkg.sv
rtl/core/line_sensor_calibrate_classify_unit.sv
dv/tb_line_sensor_calibrate_classify_unit.sv
